>>> rtl/dsca_pkg.sv
// dsca_pkg: shared types, register and mode codes, and fold helper functions
// for the dma sniff crc accumulator. No dependencies.
`default_nettype none

package dsca_pkg;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_SNIFF_ENABLE    = 3'd0;
  localparam logic [2:0] REG_WATCHED_CHANNEL = 3'd1;
  localparam logic [2:0] REG_CALC_MODE       = 3'd2;
  localparam logic [2:0] REG_SWAP_BYTES      = 3'd3;
  localparam logic [2:0] REG_REVERSE_OUTPUT  = 3'd4;
  localparam logic [2:0] REG_INVERT_OUTPUT   = 3'd5;

  // calc modes
  localparam logic [3:0] MODE_CRC32     = 4'h0;
  localparam logic [3:0] MODE_CRC32_REV = 4'h1;
  localparam logic [3:0] MODE_CRC16     = 4'h2;
  localparam logic [3:0] MODE_CRC16_REV = 4'h3;
  localparam logic [3:0] MODE_XOR       = 4'hE;
  localparam logic [3:0] MODE_SUM       = 4'hF;

  // item ops
  localparam logic OP_FOLD = 1'b0;
  localparam logic OP_SEED = 1'b1;

  // element sizes
  localparam logic [1:0] SIZE_1 = 2'd0;
  localparam logic [1:0] SIZE_2 = 2'd1;
  localparam logic [1:0] SIZE_4 = 2'd2;
  localparam logic [1:0] SIZE_8 = 2'd3;

  localparam logic [31:0] POLY_CRC32     = 32'h04C1_1DB7;
  localparam logic [31:0] POLY_CRC32_REV = 32'hEDB8_8320;
  localparam logic [15:0] POLY_CRC16     = 16'h1021;
  localparam logic [15:0] POLY_CRC16_REV = 16'h8408;

  typedef struct packed {
    logic       sniff_enable;
    logic [3:0] watched_channel;
    logic [3:0] calc_mode;
    logic       swap_bytes;
    logic       reverse_output;
    logic       invert_output;
  } cfg_t;

  typedef struct packed {
    logic        op;
    logic [3:0]  channel;
    logic        channel_sniff_on;
    logic [31:0] data;
    logic [1:0]  size_log2;
  } item_t;

  function automatic logic [31:0] rev32(input logic [31:0] v);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) begin
      r[i] = v[31-i];
    end
    return r;
  endfunction

  function automatic logic [31:0] swap_by_size(input logic [31:0] v, input logic [1:0] sz);
    logic [31:0] r;
    if (sz == SIZE_1) begin
      r = v;
    end else if (sz == SIZE_2) begin
      r = {16'h0000, v[7:0], v[15:8]};
    end else begin
      r = {v[7:0], v[15:8], v[23:16], v[31:24]};
    end
    return r;
  endfunction

  // one byte of crc; mode is the low two bits of a crc mode code
  function automatic logic [31:0] crc_byte(input logic [31:0] acc, input logic [7:0] b,
                                           input logic [1:0] mode);
    logic [31:0] c;
    logic [15:0] h;
    c = acc;
    h = acc[15:0];
    case (mode)
      MODE_CRC32[1:0]: begin
        c = acc ^ {b, 24'h000000};
        for (int k = 0; k < 8; k++) begin
          c = c[31] ? ({c[30:0], 1'b0} ^ POLY_CRC32) : {c[30:0], 1'b0};
        end
      end
      MODE_CRC32_REV[1:0]: begin
        c = acc ^ {24'h000000, b};
        for (int k = 0; k < 8; k++) begin
          c = c[0] ? ({1'b0, c[31:1]} ^ POLY_CRC32_REV) : {1'b0, c[31:1]};
        end
      end
      MODE_CRC16[1:0]: begin
        h = acc[15:0] ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
          h = h[15] ? ({h[14:0], 1'b0} ^ POLY_CRC16) : {h[14:0], 1'b0};
        end
        c = {16'h0000, h};
      end
      default: begin
        h = acc[15:0] ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
          h = h[0] ? ({1'b0, h[15:1]} ^ POLY_CRC16_REV) : {1'b0, h[15:1]};
        end
        c = {16'h0000, h};
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/dsca_if.sv
// dsca_item_if / dsca_result_if: valid-ready channels for input beats and
// result beats of the dma sniff crc accumulator. No dependencies.
`default_nettype none

interface dsca_item_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [3:0]  channel;
  logic        channel_sniff_on;
  logic [31:0] data;
  logic [1:0]  size_log2;

  modport source (output valid, op, channel, channel_sniff_on, data, size_log2,
                  input ready);
  modport sink   (input valid, op, channel, channel_sniff_on, data, size_log2,
                  output ready);
endinterface

interface dsca_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] sniff_view;
  logic        folded;

  modport source (output valid, sniff_view, folded, input ready);
  modport sink   (input valid, sniff_view, folded, output ready);
endinterface

`default_nettype wire

>>> rtl/dsca_fold.sv
// dsca_fold: combinational fold of one beat into the accumulator and the
// read view of the result. Depends on dsca_pkg.
`default_nettype none

module dsca_fold (
  input  wire logic [31:0]   acc,
  input  wire dsca_pkg::item_t item,
  input  wire dsca_pkg::cfg_t  cfg,
  output logic [31:0]        acc_next,
  output logic               folded,
  output logic [31:0]        view
);

  logic        pass;
  logic [1:0]  sz;
  logic [31:0] v;
  logic [31:0] c1;
  logic [31:0] c2;
  logic [31:0] c3;
  logic [31:0] c4;
  logic [31:0] crc;
  logic [31:0] rv;

  assign pass = (item.op == dsca_pkg::OP_FOLD) && cfg.sniff_enable &&
                (item.channel == cfg.watched_channel) && item.channel_sniff_on;

  // eight-byte elements act as four
  assign sz = (item.size_log2 == dsca_pkg::SIZE_8) ? dsca_pkg::SIZE_4 : item.size_log2;
  assign v  = cfg.swap_bytes ? dsca_pkg::swap_by_size(item.data, sz) : item.data;

  assign c1 = dsca_pkg::crc_byte(acc, v[7:0],   cfg.calc_mode[1:0]);
  assign c2 = dsca_pkg::crc_byte(c1,  v[15:8],  cfg.calc_mode[1:0]);
  assign c3 = dsca_pkg::crc_byte(c2,  v[23:16], cfg.calc_mode[1:0]);
  assign c4 = dsca_pkg::crc_byte(c3,  v[31:24], cfg.calc_mode[1:0]);

  always_comb begin
    unique case (sz)
      dsca_pkg::SIZE_1: crc = c1;
      dsca_pkg::SIZE_2: crc = c2;
      default:          crc = c4;
    endcase
  end

  always_comb begin
    acc_next = acc;
    folded   = 1'b0;
    if (item.op == dsca_pkg::OP_SEED) begin
      acc_next = item.data;
    end else if (pass) begin
      if (cfg.calc_mode == dsca_pkg::MODE_SUM) begin
        acc_next = acc + v;
        folded   = 1'b1;
      end else if (cfg.calc_mode == dsca_pkg::MODE_XOR) begin
        acc_next = acc ^ v;
        folded   = 1'b1;
      end else if (cfg.calc_mode[3:2] == 2'b00) begin
        acc_next = crc;
        folded   = 1'b1;
      end
    end
  end

  assign rv   = cfg.reverse_output ? dsca_pkg::rev32(acc_next) : acc_next;
  assign view = cfg.invert_output ? ~rv : rv;

endmodule

`default_nettype wire

>>> rtl/dma_sniff_crc_accumulator.sv
// dma_sniff_crc_accumulator: top level with input register, accumulator,
// result register and apb register file. Depends on dsca_pkg, dsca_if, dsca_fold.
//
// Usage:
//   item   - valid/ready input channel; each beat is either a seed load
//            (op = 1) or one dma element (op = 0) with channel, per-channel
//            sniff bit, data and size.
//   result - valid/ready output channel; one beat per input beat, carrying
//            the read view of the accumulator after that item and a flag
//            that says whether the element was folded.
//   apb    - configuration registers at byte addresses 0x00..0x14; write
//            only while no beat is in flight. pready is tied high.
// An accepted beat moves from the input register through the fold logic into
// the result register. Throughput: one beat per cycle while the receiver
// does not stall; the accumulator feedback through the fold logic (up to
// four crc bytes) is combinational. Reset clears the accumulator, the
// config registers and the valid flags of both pipeline stages. While the
// receiver stalls, the result register holds and the input register fills;
// item.ready drops once both are occupied.
`default_nettype none

module dma_sniff_crc_accumulator (
  input  wire logic                          clk,
  input  wire logic                          rst,
  dsca_item_if.sink                          item,
  dsca_result_if.source                      result,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [dsca_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [dsca_pkg::DATA_W-1:0]   pwdata,
  output logic      [dsca_pkg::DATA_W-1:0]   prdata,
  output logic                               pready
);

  dsca_pkg::cfg_t  cfg;
  dsca_pkg::item_t s1_item;
  logic            s1_valid;
  logic            s1_adv;
  logic [31:0]     acc;
  logic [31:0]     acc_next;
  logic            fold_hit;
  logic [31:0]     fold_view;
  logic            out_valid;
  logic [31:0]     out_view;
  logic            out_folded;
  logic            cfg_wr;
  logic [2:0]      reg_idx;

  // register file
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        dsca_pkg::REG_SNIFF_ENABLE:    cfg.sniff_enable    <= pwdata[0];
        dsca_pkg::REG_WATCHED_CHANNEL: cfg.watched_channel <= pwdata[3:0];
        dsca_pkg::REG_CALC_MODE:       cfg.calc_mode       <= pwdata[3:0];
        dsca_pkg::REG_SWAP_BYTES:      cfg.swap_bytes      <= pwdata[0];
        dsca_pkg::REG_REVERSE_OUTPUT:  cfg.reverse_output  <= pwdata[0];
        dsca_pkg::REG_INVERT_OUTPUT:   cfg.invert_output   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      dsca_pkg::REG_SNIFF_ENABLE:    prdata = {31'd0, cfg.sniff_enable};
      dsca_pkg::REG_WATCHED_CHANNEL: prdata = {28'd0, cfg.watched_channel};
      dsca_pkg::REG_CALC_MODE:       prdata = {28'd0, cfg.calc_mode};
      dsca_pkg::REG_SWAP_BYTES:      prdata = {31'd0, cfg.swap_bytes};
      dsca_pkg::REG_REVERSE_OUTPUT:  prdata = {31'd0, cfg.reverse_output};
      dsca_pkg::REG_INVERT_OUTPUT:   prdata = {31'd0, cfg.invert_output};
      default:                       prdata = '0;
    endcase
  end

  // pipeline control
  assign s1_adv     = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_item.op               <= item.op;
      s1_item.channel          <= item.channel;
      s1_item.channel_sniff_on <= item.channel_sniff_on;
      s1_item.data             <= item.data;
      s1_item.size_log2        <= item.size_log2;
    end
  end

  dsca_fold u_fold (
    .acc      (acc),
    .item     (s1_item),
    .cfg      (cfg),
    .acc_next (acc_next),
    .folded   (fold_hit),
    .view     (fold_view)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (s1_adv) begin
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_view   <= fold_view;
      out_folded <= fold_hit;
    end
  end

  assign result.valid      = out_valid;
  assign result.sniff_view = out_view;
  assign result.folded     = out_folded;

  // seed beat loads its data
  a_seed_load: assert property (@(posedge clk) disable iff (rst)
    s1_adv && (s1_item.op == dsca_pkg::OP_SEED) |=> acc == $past(s1_item.data))
    else $error("seed not loaded");

  // accumulator only moves when a beat leaves the input register
  a_acc_hold: assert property (@(posedge clk) disable iff (rst)
    !s1_adv |=> $stable(acc))
    else $error("accumulator changed without a beat");

  // a beat that is not folded leaves the accumulator alone
  a_nofold_hold: assert property (@(posedge clk) disable iff (rst)
    s1_adv && (s1_item.op == dsca_pkg::OP_FOLD) && !fold_hit |=> acc == $past(acc))
    else $error("accumulator changed on unfolded beat");

  // folded results only with sniffing enabled
  a_fold_enabled: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_folded |-> cfg.sniff_enable)
    else $error("folded while sniffing disabled");

  // pipeline empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !s1_valid)
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
